FILE: rtl/htng_pkg.sv
// package: constants, sine table, gain table and sequencer states for the tone generator
`timescale 1ns / 1ps

package htng_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int HARMONIC_COUNT  = 4;

    // quarter wave of the sine table, one extra entry for the quadrant edge
    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int QIDX_W  = SINE_TABLE_BITS - 1;
    localparam int HCNT_W  = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [15:0] LCG_MUL_LO = LCG_MUL[15:0];
    localparam logic [15:0] LCG_MUL_HI = LCG_MUL[31:16];
    localparam logic [31:0] POLY_A     = 32'd51472;
    localparam logic [31:0] POLY_B     = 32'd21078;
    localparam logic [31:0] POLY_C     = 32'd2374;
    localparam logic [15:0] NOISE_COEF = 16'd1311;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // accumulator holds tone, then mix, then mix times gain
    localparam int ACC_W     = 58;
    localparam int RND_SHIFT = 54 - SAMPLE_BITS;
    localparam int RS_W      = ACC_W - RND_SHIFT;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [RS_W-1:0]  RS_MAX   = RS_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RS_W-1:0]  RS_MIN   = -RS_MAX - RS_W'(1);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_LEVEL_GAIN = 2'd1;
    localparam logic [1:0] REG_MONITOR    = 2'd2;

    localparam logic [31:0] PHASE_STEP_RESET = 32'd39370534;
    localparam logic [15:0] LEVEL_GAIN_RESET = 16'd16384;

    typedef logic [15:0] qsine_t [QUARTER+1];
    typedef logic [15:0] gain_tab_t [HARMONIC_COUNT];
    typedef logic [15:0] gain_all_t [8];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HARM,
        ST_LCG_LO,
        ST_LCG_HI,
        ST_NOISE,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rnd15(input logic [31:0] v);
        return (v + 32'd16384) >> 15;
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t      tab;
        logic [31:0] t;
        logic [31:0] t2;
        logic [31:0] inner;
        logic [31:0] mid;
        logic [31:0] y;
        for (int i = 0; i <= QUARTER; i++)
        begin
            t     = 32'(i) << (17 - SINE_TABLE_BITS);
            t2    = rnd15(t * t);
            inner = POLY_B - rnd15(t2 * POLY_C);
            mid   = POLY_A - rnd15(t2 * inner);
            y     = rnd15(t * mid);
            if (y > 32'd32767)
                y = 32'd32767;
            tab[i] = y[15:0];
        end
        return tab;
    endfunction

    localparam gain_all_t GAIN_ALL = '{16'd32768, 16'd14746, 16'd7209, 16'd3604,
                                       16'd1802, 16'd901, 16'd451, 16'd225};

    function automatic gain_tab_t build_gains();
        gain_tab_t g;
        for (int i = 0; i < HARMONIC_COUNT; i++)
        begin
            g[i] = GAIN_ALL[i];
        end
        return g;
    endfunction

    localparam qsine_t    QSINE      = build_qsine();
    localparam gain_tab_t HARM_GAINS = build_gains();

endpackage

FILE: rtl/harmonic_tone_noise_generator_core.sv
// top level: harmonic tone plus lcg noise generator on one shared multiplier
`timescale 1ns / 1ps

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------
// input     | in        | in_valid/in_stall  | mic_sample, mic_present
// output    | out       | out_valid/out_stall| out_sample, analyser_sample
// config    | in/out    | apb write/read     | phase_step, level_gain, monitor_enable
//
// one request steps through the accept in idle, ST_HARM once per harmonic, ST_LCG_LO and
// ST_LCG_HI for the lcg, ST_NOISE for the noise term, ST_GAIN_LO and ST_GAIN_HI for the level
// gain and ST_OUT to round and load the output register, all through one 33x18 multiplier.
// in_stall is high from accept until the sequencer is back in idle; a stalled output
// holds the sequencer in its last step. reset clears phase, lcg and registers to defaults.

module harmonic_tone_noise_generator_core (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic signed [htng_pkg::SAMPLE_BITS-1:0]    mic_sample,
    input  logic                                       mic_present,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [htng_pkg::SAMPLE_BITS-1:0]    out_sample,
    output logic signed [htng_pkg::SAMPLE_BITS-1:0]    analyser_sample,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [htng_pkg::ADDR_W-1:0]                paddr,
    input  logic [31:0]                                pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    htng_pkg::state_t state_reg, state_next;

    logic [31:0] phase_step_reg;
    logic [15:0] level_gain_reg;
    logic        monitor_reg;
    logic [31:0] phase_acc_reg, phase_acc_next;
    logic [31:0] lcg_reg, lcg_next;
    logic [htng_pkg::HCNT_W-1:0] h_cnt_reg, h_cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] ph_reg, ph_next;
    logic signed [htng_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [31:0] part_reg, part_next;
    logic signed [htng_pkg::SAMPLE_BITS-1:0] mic_reg, mic_next;
    logic        mic_present_reg, mic_present_next;
    logic signed [htng_pkg::SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic signed [htng_pkg::SAMPLE_BITS-1:0] analyser_reg, analyser_next;

    logic signed [htng_pkg::MUL_A_W-1:0] mul_a;
    logic signed [htng_pkg::MUL_B_W-1:0] mul_b;
    logic signed [htng_pkg::MUL_P_W-1:0] mul_p;

    logic        in_accept;
    logic        out_free;
    logic        cfg_write;
    logic        last_harm;

    logic [htng_pkg::SINE_TABLE_BITS-1:0] sine_k;
    logic [htng_pkg::SINE_TABLE_BITS-3:0] sine_r;
    logic [htng_pkg::QIDX_W-1:0]          sine_idx;
    logic [15:0]                          sine_mag;
    logic signed [16:0]                   sine_val;
    logic signed [23:0]                   noise_val;

    logic signed [htng_pkg::ACC_W-1:0] rnd_sum;
    logic signed [htng_pkg::RS_W-1:0]  rs;
    logic signed [htng_pkg::SAMPLE_BITS-1:0] sat_sample;

    assign in_stall  = (state_reg != htng_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite;
    assign last_harm = (h_cnt_reg == htng_pkg::HCNT_W'(htng_pkg::HARMONIC_COUNT - 1));

    assign out_valid       = out_valid_reg;
    assign out_sample      = out_sample_reg;
    assign analyser_sample = analyser_reg;
    assign pready          = 1'b1;

    // sine lookup from quarter table
    assign sine_k   = ph_reg[31 -: htng_pkg::SINE_TABLE_BITS];
    assign sine_r   = sine_k[htng_pkg::SINE_TABLE_BITS-3:0];
    assign sine_idx = sine_k[htng_pkg::SINE_TABLE_BITS-2]
                      ? (htng_pkg::QIDX_W'(htng_pkg::QUARTER) - {1'b0, sine_r})
                      : {1'b0, sine_r};
    assign sine_mag = htng_pkg::QSINE[sine_idx];
    assign sine_val = sine_k[htng_pkg::SINE_TABLE_BITS-1]
                      ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    // (lcg >> 8) - 2^23 is the top 24 bits with the msb flipped
    assign noise_val = $signed({~lcg_reg[31], lcg_reg[30:8]});

    assign mul_p = mul_a * mul_b;

    assign rnd_sum = acc_reg + htng_pkg::RND_HALF;
    assign rs      = $signed(rnd_sum[htng_pkg::ACC_W-1:htng_pkg::RND_SHIFT]);

    always_comb
    begin
        if (rs > htng_pkg::RS_MAX)
            sat_sample = htng_pkg::RS_MAX[htng_pkg::SAMPLE_BITS-1:0];
        else if (rs < htng_pkg::RS_MIN)
            sat_sample = htng_pkg::RS_MIN[htng_pkg::SAMPLE_BITS-1:0];
        else
            sat_sample = rs[htng_pkg::SAMPLE_BITS-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htng_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = htng_pkg::ST_HARM;
            end
            htng_pkg::ST_HARM:
            begin
                if (last_harm)
                    state_next = htng_pkg::ST_LCG_LO;
            end
            htng_pkg::ST_LCG_LO:  state_next = htng_pkg::ST_LCG_HI;
            htng_pkg::ST_LCG_HI:  state_next = htng_pkg::ST_NOISE;
            htng_pkg::ST_NOISE:   state_next = htng_pkg::ST_GAIN_LO;
            htng_pkg::ST_GAIN_LO: state_next = htng_pkg::ST_GAIN_HI;
            htng_pkg::ST_GAIN_HI: state_next = htng_pkg::ST_OUT;
            htng_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = htng_pkg::ST_IDLE;
            end
            default:              state_next = htng_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mul_a            = '0;
        mul_b            = '0;
        phase_acc_next   = phase_acc_reg;
        lcg_next         = lcg_reg;
        h_cnt_next       = h_cnt_reg;
        ph_next          = ph_reg;
        acc_next         = acc_reg;
        part_next        = part_reg;
        mic_next         = mic_reg;
        mic_present_next = mic_present_reg;
        out_sample_next  = out_sample_reg;
        analyser_next    = analyser_reg;
        out_valid_next   = out_valid_reg && out_stall;
        case (state_reg)
            htng_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    ph_next          = phase_acc_reg;
                    acc_next         = '0;
                    h_cnt_next       = '0;
                    mic_next         = mic_sample;
                    mic_present_next = mic_present;
                end
            end
            htng_pkg::ST_HARM:
            begin
                mul_a      = htng_pkg::MUL_A_W'(sine_val);
                mul_b      = $signed({2'b00, htng_pkg::HARM_GAINS[h_cnt_reg]});
                acc_next   = acc_reg + htng_pkg::ACC_W'(mul_p);
                ph_next    = ph_reg + phase_acc_reg;
                h_cnt_next = h_cnt_reg + htng_pkg::HCNT_W'(1);
            end
            htng_pkg::ST_LCG_LO:
            begin
                mul_a     = $signed({1'b0, lcg_reg});
                mul_b     = $signed({2'b00, htng_pkg::LCG_MUL_LO});
                part_next = mul_p[31:0] + htng_pkg::LCG_ADD;
            end
            htng_pkg::ST_LCG_HI:
            begin
                mul_a    = $signed({1'b0, lcg_reg});
                mul_b    = $signed({2'b00, htng_pkg::LCG_MUL_HI});
                lcg_next = part_reg + {mul_p[15:0], 16'h0000};
            end
            htng_pkg::ST_NOISE:
            begin
                // mix = tone * 128 + noise * 1311
                mul_a    = htng_pkg::MUL_A_W'(noise_val);
                mul_b    = $signed({2'b00, htng_pkg::NOISE_COEF});
                acc_next = (acc_reg <<< 7) + htng_pkg::ACC_W'(mul_p);
            end
            htng_pkg::ST_GAIN_LO:
            begin
                mul_a     = $signed({17'h00000, acc_reg[15:0]});
                mul_b     = $signed({2'b00, level_gain_reg});
                part_next = mul_p[31:0];
            end
            htng_pkg::ST_GAIN_HI:
            begin
                // high part of the mix times gain, shifted back over the low part
                mul_a    = acc_reg[48:16];
                mul_b    = $signed({2'b00, level_gain_reg});
                acc_next = (htng_pkg::ACC_W'(mul_p) <<< 16)
                           + $signed({26'h0000000, part_reg});
            end
            htng_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_sample;
                    analyser_next   = (monitor_reg && mic_present_reg) ? mic_reg : sat_sample;
                    phase_acc_next  = phase_acc_reg + phase_step_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_comb
    begin
        case (paddr[3:2])
            htng_pkg::REG_PHASE_STEP: prdata = phase_step_reg;
            htng_pkg::REG_LEVEL_GAIN: prdata = {16'h0000, level_gain_reg};
            htng_pkg::REG_MONITOR:    prdata = {31'h00000000, monitor_reg};
            default:                  prdata = 32'h00000000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htng_pkg::ST_IDLE;
            phase_step_reg <= htng_pkg::PHASE_STEP_RESET;
            level_gain_reg <= htng_pkg::LEVEL_GAIN_RESET;
            monitor_reg    <= 1'b0;
            phase_acc_reg  <= '0;
            lcg_reg        <= '0;
            h_cnt_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_acc_reg <= phase_acc_next;
            lcg_reg       <= lcg_next;
            h_cnt_reg     <= h_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    htng_pkg::REG_PHASE_STEP: phase_step_reg <= pwdata;
                    htng_pkg::REG_LEVEL_GAIN: level_gain_reg <= pwdata[15:0];
                    htng_pkg::REG_MONITOR:    monitor_reg    <= pwdata[0];
                    default:                  monitor_reg    <= monitor_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg          <= ph_next;
        acc_reg         <= acc_next;
        part_reg        <= part_next;
        mic_reg         <= mic_next;
        mic_present_reg <= mic_present_next;
        out_sample_reg  <= out_sample_next;
        analyser_reg    <= analyser_next;
    end

endmodule
